### sv/ordered_fifo_with_expiry_purge_defines.svh
// ----------------------------------------------------------------------------
// Ordered FIFO with expiry purge - assertion macros
// Clocked on clk and held off while rst_n is low; empty outside simulation.
// ----------------------------------------------------------------------------
`ifndef ORDERED_FIFO_WITH_EXPIRY_PURGE_DEFINES_SVH
`define ORDERED_FIFO_WITH_EXPIRY_PURGE_DEFINES_SVH

`ifndef SYNTHESIS

// Same-cycle property
`define OFP_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("ofp assertion failed");

// Antecedent this cycle, consequent next cycle
`define OFP_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("ofp assertion failed");

`else

`define OFP_ASSERT(lbl, prop)
`define OFP_ASSERT_NEXT(lbl, ante, cons)

`endif

`endif

### sv/ofp_pkg.sv
// ----------------------------------------------------------------------------
// ofp_pkg
// Shared constants, codes and controller/datapath interface types.
// ----------------------------------------------------------------------------
`default_nettype none

package ofp_pkg;

  localparam int DEPTH  = 64;
  localparam int KEY_W  = 32;
  localparam int PAY_W  = 64;
  localparam int PTR_W  = $clog2(DEPTH);
  localparam int ENTRY_W = KEY_W + PAY_W;

  typedef enum logic [1:0] {
    MODE_PUSH  = 2'd0,
    MODE_POP   = 2'd1,
    MODE_PEEK  = 2'd2,
    MODE_PURGE = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2,
    ST_NONE  = 2'd3
  } status_t;

  // Source of the next result word
  typedef enum logic [1:0] {
    EMIT_NONE,
    EMIT_STATUS,
    EMIT_HEAD,
    EMIT_PEND
  } emit_t;

  typedef struct packed {
    logic    push;
    logic    advance;
    logic    capture;
    logic    load_thr;
    logic    use_thr;
    emit_t   emit;
    status_t status;
    logic    last;
  } cmd_t;

  typedef struct packed {
    logic empty;
    logic full;
    logic hit;
  } stat_t;

  // Circular pointer increment, valid for any depth
  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    logic [PTR_W-1:0] r;
    if (p == PTR_W'(DEPTH - 1)) begin
      r = '0;
    end else begin
      r = p + PTR_W'(1);
    end
    return r;
  endfunction

endpackage

`default_nettype wire

### sv/ordered_fifo_with_expiry_purge.sv
// ----------------------------------------------------------------------------
// ordered_fifo_with_expiry_purge
// Circular key/payload FIFO with push, pop, peek and purge-up-to-key.
//
//   channel  ports                                      handshake
//   request  in_mode, in_key, in_payload                start & !busy
//   result   out_status, out_key, out_payload, out_last out_valid (1 cycle)
//
// Push, pop and peek take one cycle; the result shows the cycle after accept
// and busy stays low, so a request may be taken every cycle.
// A purge keeps busy high while it walks the entries it removes, one result per
// cycle, paced by the single read port of the entry store.
// Reset (rst_n low, synchronous) empties the queue; store contents are kept.
// Results are never stalled: each is valid for exactly one cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module ordered_fifo_with_expiry_purge (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      start,
  output logic                           busy,
  input  wire logic [1:0]                in_mode,
  input  wire logic [ofp_pkg::KEY_W-1:0] in_key,
  input  wire logic [ofp_pkg::PAY_W-1:0] in_payload,
  output logic                           out_valid,
  output logic [1:0]                     out_status,
  output logic [ofp_pkg::KEY_W-1:0]      out_key,
  output logic [ofp_pkg::PAY_W-1:0]      out_payload,
  output logic                           out_last
);

  ofp_pkg::cmd_t  cmd;
  ofp_pkg::stat_t stat;

  ofp_ctrl u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (start),
    .in_mode (in_mode),
    .stat    (stat),
    .busy    (busy),
    .cmd     (cmd)
  );

  ofp_dp u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (cmd),
    .stat        (stat),
    .in_key      (in_key),
    .in_payload  (in_payload),
    .out_valid   (out_valid),
    .out_status  (out_status),
    .out_key     (out_key),
    .out_payload (out_payload),
    .out_last    (out_last)
  );

endmodule

`default_nettype wire

### sv/ofp_ram.sv
// ----------------------------------------------------------------------------
// ofp_ram
// Single write, single read RAM with registered read and write forwarding.
// ----------------------------------------------------------------------------
`default_nettype none

module ofp_ram #(
  parameter int WIDTH = 96,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Read port, forward data written to the same address
  always_ff @(posedge clk) begin
    if (wr_en && (wr_addr == rd_addr)) begin
      rd_data <= wr_data;
    end else begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

### sv/ofp_dp.sv
// ----------------------------------------------------------------------------
// ofp_dp
// Datapath: pointers, entry store, threshold, pending entry and result regs.
// ----------------------------------------------------------------------------
`default_nettype none

`include "ordered_fifo_with_expiry_purge_defines.svh"

module ofp_dp (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire ofp_pkg::cmd_t             cmd,
  output ofp_pkg::stat_t                 stat,
  input  wire logic [ofp_pkg::KEY_W-1:0] in_key,
  input  wire logic [ofp_pkg::PAY_W-1:0] in_payload,
  output logic                           out_valid,
  output logic [1:0]                     out_status,
  output logic [ofp_pkg::KEY_W-1:0]      out_key,
  output logic [ofp_pkg::PAY_W-1:0]      out_payload,
  output logic                           out_last
);

  logic [ofp_pkg::PTR_W-1:0]   head_r, head_nxt;
  logic [ofp_pkg::PTR_W-1:0]   tail_r, tail_nxt;
  logic [ofp_pkg::KEY_W-1:0]   thr_r;
  logic [ofp_pkg::KEY_W-1:0]   pend_key_r;
  logic [ofp_pkg::PAY_W-1:0]   pend_pay_r;
  logic                        out_valid_r;
  ofp_pkg::status_t            out_status_r;
  logic [ofp_pkg::KEY_W-1:0]   out_key_r, out_key_nxt;
  logic [ofp_pkg::PAY_W-1:0]   out_pay_r, out_pay_nxt;
  logic                        out_last_r;
  logic [ofp_pkg::ENTRY_W-1:0] rd_entry;
  logic [ofp_pkg::KEY_W-1:0]   rd_key;
  logic [ofp_pkg::PAY_W-1:0]   rd_pay;
  logic [ofp_pkg::KEY_W-1:0]   cmp_key;

  // Advance pointers
  assign head_nxt = cmd.advance ? ofp_pkg::ptr_inc(head_r) : head_r;
  assign tail_nxt = cmd.push    ? ofp_pkg::ptr_inc(tail_r) : tail_r;

  // Entry store; the read port always tracks the next head
  ofp_ram #(
    .WIDTH (ofp_pkg::ENTRY_W),
    .DEPTH (ofp_pkg::DEPTH)
  ) u_ram (
    .clk     (clk),
    .wr_en   (cmd.push),
    .wr_addr (tail_r),
    .wr_data ({in_key, in_payload}),
    .rd_addr (head_nxt),
    .rd_data (rd_entry)
  );

  assign rd_key = rd_entry[ofp_pkg::PAY_W +: ofp_pkg::KEY_W];
  assign rd_pay = rd_entry[ofp_pkg::PAY_W-1:0];

  // Status toward the controller
  assign cmp_key    = cmd.use_thr ? thr_r : in_key;
  assign stat.empty = (head_r == tail_r);
  assign stat.full  = (ofp_pkg::ptr_inc(tail_r) == head_r);
  assign stat.hit   = !stat.empty && (rd_key <= cmp_key);

  // Select result data
  always_comb begin
    case (cmd.emit)
      ofp_pkg::EMIT_HEAD: begin
        out_key_nxt = rd_key;
        out_pay_nxt = rd_pay;
      end
      ofp_pkg::EMIT_PEND: begin
        out_key_nxt = pend_key_r;
        out_pay_nxt = pend_pay_r;
      end
      default: begin
        out_key_nxt = '0;
        out_pay_nxt = '0;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r      <= '0;
      tail_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      head_r      <= head_nxt;
      tail_r      <= tail_nxt;
      out_valid_r <= (cmd.emit != ofp_pkg::EMIT_NONE);
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (cmd.load_thr) begin
      thr_r <= in_key;
    end
    if (cmd.capture) begin
      pend_key_r <= rd_key;
      pend_pay_r <= rd_pay;
    end
    out_status_r <= cmd.status;
    out_key_r    <= out_key_nxt;
    out_pay_r    <= out_pay_nxt;
    out_last_r   <= cmd.last;
  end

  assign out_valid   = out_valid_r;
  assign out_status  = out_status_r;
  assign out_key     = out_key_r;
  assign out_payload = out_pay_r;
  assign out_last    = out_last_r;

  `OFP_ASSERT(a_push_not_full, !cmd.push || !stat.full)
  `OFP_ASSERT(a_adv_not_empty, !cmd.advance || !stat.empty)
  `OFP_ASSERT_NEXT(a_chain_cont, out_valid_r && !out_last_r, out_valid_r)

endmodule

`default_nettype wire

### sv/ofp_ctrl.sv
// ----------------------------------------------------------------------------
// ofp_ctrl
// Controller: decodes requests and sequences the purge walk.
// ----------------------------------------------------------------------------
`default_nettype none

module ofp_ctrl (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           start,
  input  wire logic [1:0]     in_mode,
  input  wire ofp_pkg::stat_t stat,
  output logic                busy,
  output ofp_pkg::cmd_t       cmd
);

  typedef enum logic {
    S_IDLE,
    S_PURGE
  } state_t;

  state_t state_r, state_nxt;

  // Decode request and purge step
  always_comb begin
    state_nxt    = state_r;
    cmd.push     = 1'b0;
    cmd.advance  = 1'b0;
    cmd.capture  = 1'b0;
    cmd.load_thr = 1'b0;
    cmd.use_thr  = 1'b0;
    cmd.emit     = ofp_pkg::EMIT_NONE;
    cmd.status   = ofp_pkg::ST_OK;
    cmd.last     = 1'b1;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          case (ofp_pkg::mode_t'(in_mode))
            ofp_pkg::MODE_PUSH: begin
              cmd.emit = ofp_pkg::EMIT_STATUS;
              if (stat.full) begin
                cmd.status = ofp_pkg::ST_FULL;
              end else begin
                cmd.push = 1'b1;
              end
            end
            ofp_pkg::MODE_POP, ofp_pkg::MODE_PEEK: begin
              if (stat.empty) begin
                cmd.emit   = ofp_pkg::EMIT_STATUS;
                cmd.status = ofp_pkg::ST_EMPTY;
              end else begin
                cmd.emit    = ofp_pkg::EMIT_HEAD;
                cmd.advance = (ofp_pkg::mode_t'(in_mode) == ofp_pkg::MODE_POP);
              end
            end
            default: begin
              if (stat.empty) begin
                cmd.emit   = ofp_pkg::EMIT_STATUS;
                cmd.status = ofp_pkg::ST_EMPTY;
              end else if (!stat.hit) begin
                cmd.emit   = ofp_pkg::EMIT_STATUS;
                cmd.status = ofp_pkg::ST_NONE;
              end else begin
                // hold the first removed entry until its successor is known
                cmd.capture  = 1'b1;
                cmd.advance  = 1'b1;
                cmd.load_thr = 1'b1;
                state_nxt    = S_PURGE;
              end
            end
          endcase
        end
      end
      S_PURGE: begin
        cmd.use_thr = 1'b1;
        cmd.emit    = ofp_pkg::EMIT_PEND;
        if (stat.hit) begin
          cmd.last    = 1'b0;
          cmd.capture = 1'b1;
          cmd.advance = 1'b1;
        end else begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Hold state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign busy = (state_r != S_IDLE);

endmodule

`default_nettype wire
